// ===== rtl/core/cau_pkg.sv =====
// Shared types, constants and helper functions for the complex arithmetic unit.
// Used by every module under rtl/core; depends on nothing else.
package cau_pkg;

	localparam int DW   = 32;            // width of one Q16.16 value
	localparam int FRAC = 16;            // fraction bits
	localparam int PW   = 2 * DW;        // product width
	localparam int SW   = PW + 2;        // width of sums of products
	localparam int NW   = PW + FRAC + 2; // width of a divider numerator
	localparam int RW   = 2 * DW;        // radicand width of the root unit
	localparam int QW   = DW;            // quotient bits produced by the divider

	localparam logic signed [DW-1:0] MAX_V = {1'b0, {(DW-1){1'b1}}};
	localparam logic signed [DW-1:0] MIN_V = {1'b1, {(DW-1){1'b0}}};

	typedef enum logic [3:0] {
		OP_ADD   = 4'd0,
		OP_SUB   = 4'd1,
		OP_MUL   = 4'd2,
		OP_DIV   = 4'd3,
		OP_CONJ  = 4'd4,
		OP_NEG   = 4'd5,
		OP_NORM  = 4'd6,
		OP_ABS   = 4'd7,
		OP_SQRT  = 4'd8,
		OP_WEDGE = 4'd9,
		OP_SCALE = 4'd10,
		OP_RECIP = 4'd11
	} op_t;

	typedef enum logic [1:0] {
		ST_OK   = 2'd0,
		ST_DIV0 = 2'd1,
		ST_OVF  = 2'd2
	} status_t;

	// Classified item as it waits in the queue.
	typedef struct packed {
		op_t                   op;
		logic signed [DW-1:0]  ar;
		logic signed [DW-1:0]  ai;
		logic signed [DW-1:0]  br;
		logic signed [DW-1:0]  bi;
		logic signed [DW-1:0]  sx;   // operands of the squared magnitude
		logic signed [DW-1:0]  sy;
		logic                  dz;   // divisor is zero
	} item_t;

	typedef struct packed {
		logic signed [DW-1:0] val;
		logic                 ovf;
	} sat_t;

	// Control and early results carried down the back pipeline.
	typedef struct packed {
		op_t                  op;
		logic                 dz;
		logic                 ai_neg;
		logic signed [DW-1:0] ar;
		logic signed [DW-1:0] re;
		logic signed [DW-1:0] im;
		status_t              st;
	} ctl_t;

	typedef struct packed {
		logic neg;   // numerator was negative
		logic big;   // quotient magnitude is at least 2^QW
	} div_tag_t;

	typedef struct packed {
		sat_t re;
		sat_t im;
	} dres_t;

	// Saturate a wide signed value to DW bits.
	function automatic sat_t sat_sw(input logic signed [SW-1:0] v);
		sat_t r;
		if (v[SW-1:DW-1] == '0 || v[SW-1:DW-1] == '1) begin
			r.val = v[DW-1:0];
			r.ovf = 1'b0;
		end else begin
			r.val = v[SW-1] ? MIN_V : MAX_V;
			r.ovf = 1'b1;
		end
		return r;
	endfunction

	// Turn an unsigned quotient and remainder flag into a floored, saturated value.
	function automatic sat_t div_fix(input logic [QW-1:0] q, input logic rem_nz,
			input div_tag_t tag);
		sat_t       r;
		logic [QW:0] mq;
		logic [QW:0] nm;
		mq = {1'b0, q} + (QW+1)'(rem_nz);
		nm = ~mq + (QW+1)'(1);
		if (tag.big) begin
			r.val = tag.neg ? MIN_V : MAX_V;
			r.ovf = 1'b1;
		end else if (!tag.neg) begin
			if ({1'b0, q} > (QW+1)'(MAX_V)) begin
				r.val = MAX_V;
				r.ovf = 1'b1;
			end else begin
				r.val = q[DW-1:0];
				r.ovf = 1'b0;
			end
		end else begin
			if (mq > ((QW+1)'(1) << (DW-1))) begin
				r.val = MIN_V;
				r.ovf = 1'b1;
			end else begin
				r.val = nm[DW-1:0];
				r.ovf = 1'b0;
			end
		end
		return r;
	endfunction

endpackage

// ===== rtl/core/complex_arithmetic_unit.sv =====
// Complex arithmetic unit, top level.
// Input channel s_axis: one transaction carries an opcode in tuser and two complex
// operands a and b in tdata, all values signed Q16.16. Output channel m_axis: one
// transaction per input, the complex result in tdata and a status code in tuser
// (ok, divide by zero, or saturated overflow).
// The front end decodes each transaction and writes it into a four-entry queue;
// the back end is a single pipeline that pops the queue and always takes the same
// number of stages, so results leave in the order they arrived.
// Latency is set by the chain of two 32-stage square root units that the square
// root opcode needs. Division runs through two 32-stage dividers in parallel.
// Throughput is one transaction per cycle while the output is not stalled.
// When m_axis_tready is low with a result waiting, the whole back pipeline holds;
// the queue keeps accepting until its four entries are full, then s_axis_tready
// drops. Reset (arst_n low) empties the queue and all pipeline valid bits.
// Depends on cau_pkg, cau_front, cau_queue and cau_back.
module complex_arithmetic_unit import cau_pkg::*; (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          s_axis_tvalid,
	output logic          s_axis_tready,
	input  logic [127:0]  s_axis_tdata,  // a_re, a_im, b_re, b_im (lowest first)
	input  logic [3:0]    s_axis_tuser,  // op
	output logic          m_axis_tvalid,
	input  logic          m_axis_tready,
	output logic [63:0]   m_axis_tdata,  // r_re, r_im (lowest first)
	output logic [1:0]    m_axis_tuser   // status
);

	logic  push;
	item_t push_item;
	logic  full;
	logic  pop;
	item_t head;
	logic  head_valid;

	// Decode and operand selection.
	cau_front u_front (
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.full          (full),
		.push          (push),
		.push_item     (push_item)
	);

	// Short queue so the front keeps taking transactions while the back stalls.
	cau_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_item  (push_item),
		.full       (full),
		.pop        (pop),
		.head       (head),
		.head_valid (head_valid)
	);

	// Arithmetic pipeline and output register.
	cau_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.head          (head),
		.head_valid    (head_valid),
		.pop           (pop),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser)
	);

endmodule

// ===== rtl/core/cau_queue.sv =====
// Four-entry queue of classified items between the front and the back.
// Depends on cau_pkg for the item type.
module cau_queue import cau_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  push,
	input  item_t push_item,
	output logic  full,
	input  logic  pop,
	output item_t head,
	output logic  head_valid
);

	localparam int DEPTH = 4;
	localparam int AW    = $clog2(DEPTH);

	item_t          mem_q [DEPTH];
	logic [AW-1:0]  wr_q;
	logic [AW-1:0]  rd_q;
	logic [AW:0]    cnt_q;

	logic do_pop;

	assign full       = (cnt_q == (AW+1)'(DEPTH));
	assign head_valid = (cnt_q != '0);
	assign head       = mem_q[rd_q];
	assign do_pop     = pop && head_valid;

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= wr_q + AW'(1);
			end
			if (do_pop) begin
				rd_q <= rd_q + AW'(1);
			end
			if (push && !do_pop) begin
				cnt_q <= cnt_q + (AW+1)'(1);
			end else if (do_pop && !push) begin
				cnt_q <= cnt_q - (AW+1)'(1);
			end
		end
	end

endmodule

// ===== rtl/core/cau_front.sv =====
// Front end: takes input transactions, decodes the opcode and picks the operands.
// Depends on cau_pkg; feeds cau_queue.
module cau_front import cau_pkg::*; (
	input  logic          s_axis_tvalid,
	output logic          s_axis_tready,
	input  logic [127:0]  s_axis_tdata,  // a_re, a_im, b_re, b_im (lowest first)
	input  logic [3:0]    s_axis_tuser,  // op
	input  logic          full,
	output logic          push,
	output item_t         push_item
);

	op_t                  opc;
	logic signed [DW-1:0] ar, ai, br, bi;

	assign s_axis_tready = !full;
	assign push          = s_axis_tvalid && !full;

	assign opc = op_t'(s_axis_tuser);
	assign ar  = s_axis_tdata[DW-1:0];
	assign ai  = s_axis_tdata[2*DW-1:DW];
	assign br  = s_axis_tdata[3*DW-1:2*DW];
	assign bi  = s_axis_tdata[4*DW-1:3*DW];

	always_comb begin
		push_item.op = opc;
		push_item.ar = ar;
		push_item.ai = ai;
		push_item.br = br;
		push_item.bi = bi;
		unique case (opc)
			OP_DIV: begin
				push_item.sx = br;
				push_item.sy = bi;
				push_item.dz = (br == '0) && (bi == '0);
			end
			OP_RECIP: begin
				push_item.sx = ar;
				push_item.sy = ai;
				push_item.dz = (ar == '0) && (ai == '0);
			end
			default: begin
				push_item.sx = ar;
				push_item.sy = ai;
				push_item.dz = 1'b0;
			end
		endcase
	end

endmodule

// ===== rtl/core/cau_isqrt.sv =====
// Pipelined integer square root, one result bit per stage.
// Depends on cau_pkg for widths.
module cau_isqrt import cau_pkg::*; (
	input  logic            clk,
	input  logic            en,
	input  logic [RW-1:0]   rad,
	output logic [RW/2-1:0] root
);

	localparam int STG  = RW / 2;
	localparam int REMW = STG + 2;

	logic [REMW-1:0] rem_q  [STG];
	logic [STG-1:0]  root_q [STG];
	logic [RW-1:0]   rad_q  [STG];
	logic [REMW-1:0] rem_d  [STG];
	logic [STG-1:0]  root_d [STG];
	logic [RW-1:0]   rad_d  [STG];

	for (genvar g = 0; g < STG; g++) begin : g_stage
		logic [REMW-1:0] rem_i;
		logic [STG-1:0]  root_i;
		logic [RW-1:0]   rad_i;
		logic [REMW+1:0] t;
		logic [REMW+1:0] trial;

		if (g == 0) begin : g_first
			assign rem_i  = '0;
			assign root_i = '0;
			assign rad_i  = rad;
		end else begin : g_next
			assign rem_i  = rem_q[g-1];
			assign root_i = root_q[g-1];
			assign rad_i  = rad_q[g-1];
		end

		assign t     = {rem_i, rad_i[RW-1 -: 2]};
		assign trial = (REMW+2)'({root_i, 2'b01});

		assign rem_d[g]  = (t >= trial) ? REMW'(t - trial) : t[REMW-1:0];
		assign root_d[g] = {root_i[STG-2:0], (t >= trial)};
		assign rad_d[g]  = {rad_i[RW-3:0], 2'b00};
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rem_q  <= rem_d;
			root_q <= root_d;
			rad_q  <= rad_d;
		end
	end

	assign root = root_q[STG-1];

endmodule

// ===== rtl/core/cau_div.sv =====
// Pipelined restoring divider, one quotient bit per stage, with a tag carried along.
// Depends on cau_pkg for widths and the tag type.
module cau_div import cau_pkg::*; (
	input  logic          clk,
	input  logic          en,
	input  logic [PW-1:0] rem_in,   // upper numerator bits, below the divisor
	input  logic [QW-1:0] low_in,   // numerator bits still to bring down
	input  logic [PW-1:0] dvs,
	input  div_tag_t      tag_in,
	output logic [QW-1:0] quo,
	output logic          rem_nz,
	output div_tag_t      tag_out
);

	localparam int STG = QW;

	logic [PW-1:0] rem_q [STG];
	logic [QW-1:0] low_q [STG];
	logic [QW-1:0] quo_q [STG];
	logic [PW-1:0] dvs_q [STG];
	div_tag_t      tag_q [STG];
	logic [PW-1:0] rem_d [STG];
	logic [QW-1:0] low_d [STG];
	logic [QW-1:0] quo_d [STG];
	logic [PW-1:0] dvs_d [STG];
	div_tag_t      tag_d [STG];

	for (genvar g = 0; g < STG; g++) begin : g_stage
		logic [PW-1:0] rem_i;
		logic [QW-1:0] low_i;
		logic [QW-1:0] quo_i;
		logic [PW-1:0] dvs_i;
		div_tag_t      tag_i;
		logic [PW:0]   t;
		logic          ge;

		if (g == 0) begin : g_first
			assign rem_i = rem_in;
			assign low_i = low_in;
			assign quo_i = '0;
			assign dvs_i = dvs;
			assign tag_i = tag_in;
		end else begin : g_next
			assign rem_i = rem_q[g-1];
			assign low_i = low_q[g-1];
			assign quo_i = quo_q[g-1];
			assign dvs_i = dvs_q[g-1];
			assign tag_i = tag_q[g-1];
		end

		assign t  = {rem_i, low_i[QW-1]};
		assign ge = (t >= {1'b0, dvs_i});

		assign rem_d[g] = ge ? PW'(t - {1'b0, dvs_i}) : t[PW-1:0];
		assign low_d[g] = {low_i[QW-2:0], 1'b0};
		assign quo_d[g] = {quo_i[QW-2:0], ge};
		assign dvs_d[g] = dvs_i;
		assign tag_d[g] = tag_i;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rem_q <= rem_d;
			low_q <= low_d;
			quo_q <= quo_d;
			dvs_q <= dvs_d;
			tag_q <= tag_d;
		end
	end

	assign quo     = quo_q[STG-1];
	assign rem_nz  = |rem_q[STG-1];
	assign tag_out = tag_q[STG-1];

endmodule

// ===== rtl/core/cau_back.sv =====
// Back end: multipliers, sums, dividers and root units in one stalling pipeline,
// ending in the output register. Depends on cau_pkg, cau_div and cau_isqrt.
module cau_back import cau_pkg::*; (
	input  logic          clk,
	input  logic          arst_n,
	input  item_t         head,
	input  logic          head_valid,
	output logic          pop,
	output logic          m_axis_tvalid,
	input  logic          m_axis_tready,
	output logic [63:0]   m_axis_tdata,  // r_re, r_im (lowest first)
	output logic [1:0]    m_axis_tuser   // status
);

	localparam int S_SQ1  = 2 + RW / 2;      // magnitude root ready
	localparam int S_PQ   = S_SQ1 + 1;       // half-angle radicands registered
	localparam int S_LAST = S_PQ + RW / 2;   // last stage before the output register
	localparam int S_DIV  = 4 + QW;          // divider outputs ready
	localparam int S_DRES = S_DIV + 1;       // divider results fixed up

	logic en;
	logic [S_LAST:1] vld_q;
	logic            out_valid_q;

	// stage 1
	item_t                it_s1;
	logic signed [PW-1:0] p0_s1, p1_s1, p2_s1, p3_s1, p4_s1, p5_s1;
	// stage 2
	ctl_t                 ctl_d;
	ctl_t                 ctl_q [2:S_LAST];
	logic signed [SW-1:0] dre_s2, dim_s2;
	logic [PW-1:0]        md_s2;
	logic signed [DW-1:0] ar_s2, ai_s2;
	// stage 3
	logic [NW-1:0]        mag_re_s3, mag_im_s3;
	logic                 neg_re_s3, neg_im_s3;
	logic [PW-1:0]        md_s3;
	// stage 4
	logic [PW-1:0]        rem_re_s4, rem_im_s4, md_s4;
	logic [QW-1:0]        low_re_s4, low_im_s4;
	div_tag_t             tag_re_s4, tag_im_s4;
	// root path
	logic [DW-1:0]        mag_root;
	logic [RW-1:0]        rad_p_s35, rad_q_s35;
	logic [DW-1:0]        root_p, root_q;
	sat_t                 abs_q [S_PQ:S_LAST];
	// divider path
	logic [QW-1:0]        quo_re, quo_im;
	logic                 rnz_re, rnz_im;
	div_tag_t             tag_re, tag_im;
	dres_t                dres_q [S_DRES:S_LAST];

	// stage 2 combinational
	logic signed [SW-1:0] mre, mim, wdg, dre, dim;
	logic [PW-1:0]        md;
	sat_t                 sr, si;
	// stage 3 combinational
	logic signed [NW-1:0] n_re, n_im;
	// root path combinational
	logic signed [DW+1:0] pv, qv;
	// final
	logic signed [DW-1:0] f_re, f_im;
	status_t              f_st;
	ctl_t                 cl;
	logic signed [DW-1:0] rp_s;

	assign en  = !out_valid_q || m_axis_tready;
	assign pop = en && head_valid;

	// ---------------- stage 1: products ----------------
	always_ff @(posedge clk) begin
		if (en) begin
			it_s1 <= head;
			p0_s1 <= PW'(head.ar) * PW'(head.br);
			p1_s1 <= PW'(head.ai) * PW'(head.bi);
			p2_s1 <= PW'(head.ar) * PW'(head.bi);
			p3_s1 <= PW'(head.ai) * PW'(head.br);
			p4_s1 <= PW'(head.sx) * PW'(head.sx);
			p5_s1 <= PW'(head.sy) * PW'(head.sy);
		end
	end

	// ---------------- stage 2: sums and direct results ----------------
	always_comb begin
		mre = SW'(p0_s1) - SW'(p1_s1);
		mim = SW'(p2_s1) + SW'(p3_s1);
		wdg = SW'(p2_s1) - SW'(p3_s1);
		dre = SW'(p0_s1) + SW'(p1_s1);
		dim = SW'(p3_s1) - SW'(p2_s1);
		md  = $unsigned(p4_s1) + $unsigned(p5_s1);
		sr  = '0;
		si  = '0;
		case (it_s1.op)
			OP_ADD: begin
				sr = sat_sw(SW'(it_s1.ar) + SW'(it_s1.br));
				si = sat_sw(SW'(it_s1.ai) + SW'(it_s1.bi));
			end
			OP_SUB: begin
				sr = sat_sw(SW'(it_s1.ar) - SW'(it_s1.br));
				si = sat_sw(SW'(it_s1.ai) - SW'(it_s1.bi));
			end
			OP_MUL: begin
				sr = sat_sw(mre >>> FRAC);
				si = sat_sw(mim >>> FRAC);
			end
			OP_CONJ: begin
				sr.val = it_s1.ar;
				sr.ovf = 1'b0;
				si = sat_sw(-SW'(it_s1.ai));
			end
			OP_NEG: begin
				sr = sat_sw(-SW'(it_s1.ar));
				si = sat_sw(-SW'(it_s1.ai));
			end
			OP_NORM: begin
				sr = sat_sw(SW'(md >> FRAC));
			end
			OP_WEDGE: begin
				sr = sat_sw(wdg >>> FRAC);
			end
			OP_SCALE: begin
				sr = sat_sw(SW'(p0_s1) >>> FRAC);
				si = sat_sw(SW'(p3_s1) >>> FRAC);
			end
			default: begin
				sr = '0;
				si = '0;
			end
		endcase
		ctl_d.op     = it_s1.op;
		ctl_d.dz     = it_s1.dz;
		ctl_d.ai_neg = it_s1.ai[DW-1];
		ctl_d.ar     = it_s1.ar;
		ctl_d.re     = sr.val;
		ctl_d.im     = si.val;
		ctl_d.st     = (sr.ovf || si.ovf) ? ST_OVF : ST_OK;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dre_s2 <= dre;
			dim_s2 <= dim;
			md_s2  <= md;
			ar_s2  <= it_s1.ar;
			ai_s2  <= it_s1.ai;
		end
	end

	// ---------------- stage 3: numerators and magnitudes ----------------
	always_comb begin
		if (ctl_q[2].op == OP_RECIP) begin
			n_re = NW'(ar_s2) <<< (2 * FRAC);
			n_im = (-NW'(ai_s2)) <<< (2 * FRAC);
		end else begin
			n_re = NW'(dre_s2) <<< FRAC;
			n_im = NW'(dim_s2) <<< FRAC;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			neg_re_s3 <= n_re[NW-1];
			neg_im_s3 <= n_im[NW-1];
			mag_re_s3 <= n_re[NW-1] ? NW'(-n_re) : NW'(n_re);
			mag_im_s3 <= n_im[NW-1] ? NW'(-n_im) : NW'(n_im);
			md_s3     <= md_s2;
		end
	end

	// ---------------- stage 4: range check and divider load ----------------
	always_ff @(posedge clk) begin
		if (en) begin
			md_s4         <= md_s3;
			rem_re_s4     <= PW'(mag_re_s3[NW-1:QW]);
			rem_im_s4     <= PW'(mag_im_s3[NW-1:QW]);
			low_re_s4     <= mag_re_s3[QW-1:0];
			low_im_s4     <= mag_im_s3[QW-1:0];
			tag_re_s4.neg <= neg_re_s3;
			tag_im_s4.neg <= neg_im_s3;
			tag_re_s4.big <= ((PW+QW)'(mag_re_s3) >= {md_s3, QW'(0)});
			tag_im_s4.big <= ((PW+QW)'(mag_im_s3) >= {md_s3, QW'(0)});
		end
	end

	cau_div u_div_re (
		.clk     (clk),
		.en      (en),
		.rem_in  (rem_re_s4),
		.low_in  (low_re_s4),
		.dvs     (md_s4),
		.tag_in  (tag_re_s4),
		.quo     (quo_re),
		.rem_nz  (rnz_re),
		.tag_out (tag_re)
	);

	cau_div u_div_im (
		.clk     (clk),
		.en      (en),
		.rem_in  (rem_im_s4),
		.low_in  (low_im_s4),
		.dvs     (md_s4),
		.tag_in  (tag_im_s4),
		.quo     (quo_im),
		.rem_nz  (rnz_im),
		.tag_out (tag_im)
	);

	// ---------------- root path ----------------
	cau_isqrt u_sqrt_mag (
		.clk  (clk),
		.en   (en),
		.rad  (md_s2),
		.root (mag_root)
	);

	// m + a_re and m - a_re are never negative, since m is at least |a_re|.
	assign pv = $signed({2'b00, mag_root}) + (DW+2)'(ctl_q[S_SQ1].ar);
	assign qv = $signed({2'b00, mag_root}) - (DW+2)'(ctl_q[S_SQ1].ar);

	always_ff @(posedge clk) begin
		if (en) begin
			rad_p_s35 <= RW'(pv[DW:0]) << (FRAC - 1);
			rad_q_s35 <= RW'(qv[DW:0]) << (FRAC - 1);
		end
	end

	cau_isqrt u_sqrt_p (
		.clk  (clk),
		.en   (en),
		.rad  (rad_p_s35),
		.root (root_p)
	);

	cau_isqrt u_sqrt_q (
		.clk  (clk),
		.en   (en),
		.rad  (rad_q_s35),
		.root (root_q)
	);

	// ---------------- alignment delay lines ----------------
	always_ff @(posedge clk) begin
		if (en) begin
			ctl_q[2] <= ctl_d;
			for (int k = 3; k <= S_LAST; k++) begin
				ctl_q[k] <= ctl_q[k-1];
			end
			abs_q[S_PQ].val <= mag_root[DW-1] ? MAX_V : $signed(mag_root);
			abs_q[S_PQ].ovf <= mag_root[DW-1];
			for (int k = S_PQ + 1; k <= S_LAST; k++) begin
				abs_q[k] <= abs_q[k-1];
			end
			dres_q[S_DRES].re <= div_fix(quo_re, rnz_re, tag_re);
			dres_q[S_DRES].im <= div_fix(quo_im, rnz_im, tag_im);
			for (int k = S_DRES + 1; k <= S_LAST; k++) begin
				dres_q[k] <= dres_q[k-1];
			end
		end
	end

	// ---------------- final selection ----------------
	assign cl   = ctl_q[S_LAST];
	assign rp_s = $signed(root_p);

	always_comb begin
		f_re = cl.re;
		f_im = cl.im;
		f_st = cl.st;
		case (cl.op) inside
			OP_ABS: begin
				f_re = abs_q[S_LAST].val;
				f_im = '0;
				f_st = abs_q[S_LAST].ovf ? ST_OVF : ST_OK;
			end
			OP_SQRT: begin
				f_re = cl.ai_neg ? -rp_s : rp_s;
				f_im = $signed(root_q);
				f_st = ST_OK;
			end
			OP_DIV, OP_RECIP: begin
				if (cl.dz) begin
					f_re = '0;
					f_im = '0;
					f_st = ST_DIV0;
				end else begin
					f_re = dres_q[S_LAST].re.val;
					f_im = dres_q[S_LAST].im.val;
					f_st = (dres_q[S_LAST].re.ovf || dres_q[S_LAST].im.ovf) ? ST_OVF : ST_OK;
				end
			end
			default: begin
				f_re = cl.re;
				f_im = cl.im;
				f_st = cl.st;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (en) begin
			m_axis_tdata <= {f_im, f_re};
			m_axis_tuser <= f_st;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q       <= '0;
			out_valid_q <= 1'b0;
		end else if (en) begin
			vld_q       <= {vld_q[S_LAST-1:1], pop};
			out_valid_q <= vld_q[S_LAST];
		end
	end

	assign m_axis_tvalid = out_valid_q;

endmodule
